// ===== sv/character_terminal_buffer_unit_macros.svh =====
// assertion macros used by the character terminal buffer datapath
`ifndef CHARACTER_TERMINAL_BUFFER_UNIT_MACROS_SVH
`define CHARACTER_TERMINAL_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CTBU_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define CTBU_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ctbu_pkg.sv =====
// types, constants and control structs of the character terminal buffer
package ctbu_pkg;

  localparam int CTBU_ROWS = 24;
  localparam int CTBU_COLS = 40;

  localparam int CMD_W  = 1;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int CELL_W = 7;

  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_FF   = 8'h0C;
  localparam logic [CHAR_W-1:0] CH_LOW  = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HIGH = 8'd126;
  localparam logic [CELL_W-1:0] CH_SPACE = 7'h20;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] character;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } req_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_char;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
  } rsp_item_t;

  typedef struct packed {
    logic take;
    logic rd_issue;
    logic clear_all;
    logic next_line;
    logic write_char;
    logic fill_step;
    logic load_out;
  } ctbu_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_ff;
    logic is_cr;
    logic is_print;
    logic cur_row_valid;
    logic fill_last;
    logic out_free;
  } ctbu_stat_t;

endpackage

// ===== sv/ctbu_ctrl.sv =====
// sequencer of the character terminal buffer
module ctbu_ctrl import ctbu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  ctbu_stat_t stat,
  output ctbu_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_FILL = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.take   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        if (stat.is_read) begin
          cmd.rd_issue = 1'b1;
        end else if (stat.is_ff) begin
          cmd.clear_all = 1'b1;
        end else if (stat.is_cr) begin
          cmd.next_line = 1'b1;
        end else if (stat.is_print) begin
          // a row blanked by reset, scroll or form feed is filled before first use
          if (stat.cur_row_valid) begin
            cmd.write_char = 1'b1;
          end else begin
            state_next = S_FILL;
          end
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_next = S_EXEC;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ctbu_dp.sv =====
// screen memory, cursor, scroll offset and result register
`include "character_terminal_buffer_unit_macros.svh"

module ctbu_dp import ctbu_pkg::*; #(
  parameter int ROWS = CTBU_ROWS,
  parameter int COLS = CTBU_COLS
) (
  input  logic       clk,
  input  logic       rst,
  input  req_item_t  req,
  input  ctbu_cmd_t  cmd,
  output ctbu_stat_t stat,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output rsp_item_t  rsp
);

  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;

  // physical row of a screen row given the top-of-screen offset
  function automatic logic [RW-1:0] wrap_row(logic [RW-1:0] base, logic [RW-1:0] off);
    logic [RW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  req_item_t        item;
  logic [CW-1:0]    cur_col;
  logic [RW-1:0]    cur_row;
  logic [RW-1:0]    top;
  logic [ROWS-1:0]  row_valid;
  logic [CW-1:0]    fill_col;
  logic [CELL_W-1:0] mem [DEPTH];
  logic [CELL_W-1:0] mem_q;
  logic             rd_in_q;
  logic             rd_hit_q;

  logic [RW-1:0]    phys_cur;
  logic [RW-1:0]    phys_rd;
  logic             rd_in;
  logic             col_last;
  logic             row_last;
  logic [RW-1:0]    top_inc;
  logic             mem_we;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [CELL_W-1:0] wr_data;
  logic             is_read;

  assign is_read  = (item.command == CMD_READ);
  assign phys_cur = wrap_row(top, cur_row);
  assign phys_rd  = wrap_row(top, RW'(item.row));
  assign rd_in    = (32'(item.row) < 32'(ROWS)) && (32'(item.col) < 32'(COLS));
  assign col_last = (cur_col == CW'(COLS - 1));
  assign row_last = (cur_row == RW'(ROWS - 1));
  assign top_inc  = (top == RW'(ROWS - 1)) ? '0 : top + 1'b1;

  assign mem_we  = cmd.fill_step || cmd.write_char;
  assign wr_addr = {phys_cur, (cmd.fill_step ? fill_col : cur_col)};
  assign wr_data = cmd.fill_step ? CH_SPACE : item.character[CELL_W-1:0];
  assign rd_addr = {phys_rd, CW'(item.col)};

  assign stat.is_read       = is_read;
  assign stat.is_ff         = !is_read && (item.character == CH_FF);
  assign stat.is_cr         = !is_read && (item.character == CH_CR);
  assign stat.is_print      = !is_read && (item.character >= CH_LOW)
                              && (item.character <= CH_HIGH);
  assign stat.cur_row_valid = row_valid[phys_cur];
  assign stat.fill_last     = (fill_col == CW'(COLS - 1));
  assign stat.out_free      = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col   <= '0;
      cur_row   <= '0;
      top       <= '0;
      row_valid <= '0;
      fill_col  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        cur_col   <= '0;
        cur_row   <= '0;
        row_valid <= '0;
      end
      if (cmd.next_line || (cmd.write_char && col_last)) begin
        cur_col <= '0;
        if (row_last) begin
          // scroll: old top row becomes the blank bottom row
          top            <= top_inc;
          row_valid[top] <= 1'b0;
        end else begin
          cur_row <= cur_row + 1'b1;
        end
      end else if (cmd.write_char) begin
        cur_col <= cur_col + 1'b1;
      end
      if (cmd.fill_step) begin
        if (stat.fill_last) begin
          fill_col            <= '0;
          row_valid[phys_cur] <= 1'b1;
        end else begin
          fill_col <= fill_col + 1'b1;
        end
      end
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_issue) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      item <= req;
    end
    if (cmd.rd_issue) begin
      rd_in_q  <= rd_in;
      rd_hit_q <= rd_in && row_valid[phys_rd];
    end
    if (cmd.load_out) begin
      rsp.cell_char  <= (is_read && rd_in_q) ? (rd_hit_q ? mem_q : CH_SPACE) : '0;
      rsp.cursor_col <= COL_W'(cur_col);
      rsp.cursor_row <= ROW_W'(cur_row);
    end
  end

  `CTBU_ASSERT_IMP(a_cursor_range, clk, rst, 1'b1,
    (32'(cur_col) < 32'(COLS)) && (32'(cur_row) < 32'(ROWS)), "cursor left the screen")
  `CTBU_ASSERT_IMP(a_top_range, clk, rst, 1'b1, 32'(top) < 32'(ROWS), "scroll offset out of range")
  `CTBU_ASSERT_IMP(a_fill_blank_row, clk, rst, cmd.fill_step, !row_valid[phys_cur],
    "fill on a row already in use")
  `CTBU_ASSERT_NXT(a_fill_marks_row, clk, rst, cmd.fill_step && stat.fill_last,
    row_valid[phys_cur], "filled row not marked valid")
  `CTBU_ASSERT_IMP(a_write_valid_row, clk, rst, cmd.write_char, row_valid[phys_cur],
    "character written into a blank row")

endmodule

// ===== sv/character_terminal_buffer_unit.sv =====
// character terminal buffer: top level joining sequencer and datapath
//
// A glass-terminal screen of ROWS x COLS seven-bit cells with a cursor.
// Request channel (req_valid / req_stall / req): command 0 puts a byte,
// command 1 reads the cell at row, col. Carriage return moves to the next
// line and scrolls at the bottom, form feed blanks the screen and homes the
// cursor, printable bytes are stored at the cursor, other bytes are ignored.
// Response channel (rsp_valid / rsp_stall / rsp): one item per request with
// the cell read (zero for put or out-of-range read) and the cursor after it.
// An accepted item passes through the execute and done states before its
// result is loaded into the output register. A printable byte landing in a
// row last blanked by reset, scroll or form feed first fills that row with
// spaces, one column per cycle through the single write port of the screen
// memory. One item is in work at a time; a new one is taken once the
// previous result sits in the output register.
// Scrolling rotates a row offset, so no rows are copied.
// Reset marks every row blank (reads return spaces) and homes the cursor;
// no clearing pass is needed. While the receiver stalls, the result holds
// in the output register and the next result waits for it to be taken.
module character_terminal_buffer_unit import ctbu_pkg::*; #(
  parameter int ROWS = CTBU_ROWS,
  parameter int COLS = CTBU_COLS
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  ctbu_cmd_t  cmd;
  ctbu_stat_t stat;

  ctbu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  ctbu_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule
